FILE: src/lpg_pkg.sv
// Package for the low-pass gate with high-pass stage.
// Holds widths, constants, microcode types, the control store and saturation helpers.
// No dependencies.
package lpg_pkg;

    // Field and state widths.
    localparam int SAMPLE_BITS = 16;
    localparam int STATE_BITS  = 24;
    localparam int FRAC        = 15;
    localparam int LVL_W       = 16;
    localparam int GAIN_W      = 18;
    localparam int HP_FB_W     = 15;
    localparam int OFFSET_W    = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Multiplier and accumulator widths.
    localparam int MA_W   = STATE_BITS + 1;
    localparam int MB_W   = GAIN_W;
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = PROD_W + 1;

    // Divider widths.
    localparam int QUOT_W    = FRAC;
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(QUOT_W);

    // Q1.15 constants.
    localparam logic [LVL_W-1:0] ONE_Q15   = LVL_W'(32768);
    localparam logic [LVL_W-1:0] HALF_Q15  = LVL_W'(16384);
    localparam logic [LVL_W-1:0] TENTH_Q15 = LVL_W'(3277);
    localparam logic [HP_FB_W-1:0] HP_FB_RESET = HP_FB_W'(32440);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC - 1));

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_MODE    = 2'd0,
        REG_HPF_ENABLE     = 2'd1,
        REG_LOG_VOL_OFFSET = 2'd2,
        REG_HP_FEEDBACK    = 2'd3
    } t_cfg_reg;

    // Microcode fields.
    localparam int PC_W = 4;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_LP,
        MUL_GAIN,
        MUL_HPF
    } t_mul_op;

    typedef enum logic [3:0] {
        ALU_NONE,
        ALU_LP,
        ALU_DIV_START,
        ALU_DIV_STEP,
        ALU_GAIN_DIV,
        ALU_GAIN_GATE,
        ALU_LO,
        ALU_HI,
        ALU_BYPASS
    } t_alu_op;

    typedef enum logic [2:0] {
        J_NEXT,
        J_ALWAYS,
        J_IF_GATE,
        J_IF_NOHPF,
        J_LOOP,
        J_DONE
    } t_jump;

    typedef struct packed {
        t_mul_op         mul;
        t_alu_op         alu;
        t_jump           jmp;
        logic [PC_W-1:0] target;
    } t_cword;

    // Sequencer states.
    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        t_mul_op mul;
        t_alu_op alu;
        logic    finish;
    } t_ctrl;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic filter_mode;
        logic hpf_enable;
        logic div_last;
        logic out_free;
    } t_status;

    // Control store: one word per step of the per-sample program.
    function automatic t_cword ucode(input logic [PC_W-1:0] pc);
        t_cword w;
        w = '{mul: MUL_NONE, alu: ALU_NONE, jmp: J_DONE, target: '0};
        unique case (pc)
            4'd0:  w = '{mul: MUL_LP,   alu: ALU_NONE,      jmp: J_NEXT,     target: 4'd0};
            4'd1:  w = '{mul: MUL_NONE, alu: ALU_LP,        jmp: J_IF_GATE,  target: 4'd5};
            4'd2:  w = '{mul: MUL_NONE, alu: ALU_DIV_START, jmp: J_NEXT,     target: 4'd0};
            4'd3:  w = '{mul: MUL_NONE, alu: ALU_DIV_STEP,  jmp: J_LOOP,     target: 4'd3};
            4'd4:  w = '{mul: MUL_NONE, alu: ALU_GAIN_DIV,  jmp: J_ALWAYS,   target: 4'd6};
            4'd5:  w = '{mul: MUL_NONE, alu: ALU_GAIN_GATE, jmp: J_NEXT,     target: 4'd0};
            4'd6:  w = '{mul: MUL_GAIN, alu: ALU_NONE,      jmp: J_NEXT,     target: 4'd0};
            4'd7:  w = '{mul: MUL_NONE, alu: ALU_LO,        jmp: J_IF_NOHPF, target: 4'd10};
            4'd8:  w = '{mul: MUL_HPF,  alu: ALU_NONE,      jmp: J_NEXT,     target: 4'd0};
            4'd9:  w = '{mul: MUL_NONE, alu: ALU_HI,        jmp: J_ALWAYS,   target: 4'd11};
            4'd10: w = '{mul: MUL_NONE, alu: ALU_BYPASS,    jmp: J_NEXT,     target: 4'd0};
            4'd11: w = '{mul: MUL_NONE, alu: ALU_NONE,      jmp: J_DONE,     target: 4'd0};
            default: w = '{mul: MUL_NONE, alu: ALU_NONE,    jmp: J_DONE,     target: 4'd0};
        endcase
        return w;
    endfunction

    // Saturate an accumulator value to the signed state range.
    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [ACC_W-1:0] v
    );
        logic fits;
        fits = (&v[ACC_W-1:STATE_BITS-1]) || (~|v[ACC_W-1:STATE_BITS-1]);
        if (fits) begin
            return v[STATE_BITS-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(STATE_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(STATE_BITS-1){1'b1}}};
        end
    endfunction

endpackage

FILE: src/lpg_divider.sv
// Serial restoring divider for the filter-mode gain: round(level / (0.1 + level)).
// One quotient bit per step. Depends on lpg_pkg.
module lpg_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_step,
    input  logic [lpg_pkg::LVL_W-1:0]  i_lvl,
    output logic [lpg_pkg::QUOT_W-1:0] o_quot,
    output logic                       o_last
);

    logic [lpg_pkg::LVL_W-1:0]     r_den;
    logic [lpg_pkg::LVL_W-1:0]     r_rem;
    logic [lpg_pkg::QUOT_W-1:0]    r_dq;
    logic [lpg_pkg::DIV_CNT_W-1:0] r_cnt;

    logic [lpg_pkg::LVL_W-1:0] w_den;
    logic [lpg_pkg::LVL_W:0]   w_trial;
    logic                      w_ge;

    // The numerator is level * 2^15 + den/2: its upper part is the level itself,
    // and its low 15 bits are den/2, which is shifted in one bit per step.
    assign w_den   = lpg_pkg::TENTH_Q15 + i_lvl;
    assign w_trial = {r_rem, r_dq[lpg_pkg::QUOT_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    // Remainder, divisor and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= w_den;
            r_rem <= i_lvl;
            r_dq  <= w_den[lpg_pkg::LVL_W-1:1];
        end else if (i_step) begin
            r_rem <= w_ge ? lpg_pkg::LVL_W'(w_trial - {1'b0, r_den})
                          : w_trial[lpg_pkg::LVL_W-1:0];
            r_dq  <= {r_dq[lpg_pkg::QUOT_W-2:0], w_ge};
        end
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= lpg_pkg::DIV_STEPS;
        end else if (i_step && (r_cnt != '0)) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_quot = r_dq;
    assign o_last = (r_cnt == lpg_pkg::DIV_CNT_W'(1));

endmodule

FILE: src/lpg_datapath.sv
// Datapath of the low-pass gate: configuration registers, filter state, one shared
// multiplier, round/saturate adder, divider and the output register.
// Depends on lpg_pkg and lpg_divider.
module lpg_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration writes.
    input  logic                                   i_cfg_we,
    input  logic [lpg_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [lpg_pkg::CFG_DATA_W-1:0]         i_cfg_wdata,
    // Input transaction.
    input  logic                                   i_accept,
    input  logic [lpg_pkg::LVL_W-1:0]              i_level,
    input  logic signed [lpg_pkg::SAMPLE_BITS-1:0] i_sample_in,
    // Sequencer interface.
    input  lpg_pkg::t_ctrl                         i_ctrl,
    output lpg_pkg::t_status                       o_status,
    // Output transaction.
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic signed [lpg_pkg::SAMPLE_BITS-1:0] o_sample_out,
    output logic                                   o_clipped
);

    // Configuration registers.
    logic                                  r_filter_mode;
    logic                                  r_hpf_enable;
    logic signed [lpg_pkg::OFFSET_W-1:0]   r_offset;
    logic [lpg_pkg::HP_FB_W-1:0]           r_hp_fb;

    // Filter state.
    logic signed [lpg_pkg::STATE_BITS-1:0] r_lp_mem;
    logic signed [lpg_pkg::STATE_BITS-1:0] r_hp_mem;

    // Working registers.
    logic [lpg_pkg::LVL_W-1:0]             r_lvl;
    logic signed [lpg_pkg::MA_W-1:0]       r_diff;
    logic signed [lpg_pkg::PROD_W-1:0]     r_prod;
    logic signed [lpg_pkg::STATE_BITS-1:0] r_lp;
    logic signed [lpg_pkg::GAIN_W-1:0]     r_gain;
    logic signed [lpg_pkg::STATE_BITS-1:0] r_lo;
    logic signed [lpg_pkg::STATE_BITS-1:0] r_hi;

    // Output register.
    logic                                  r_out_valid;
    logic signed [lpg_pkg::SAMPLE_BITS-1:0] r_out_data;
    logic                                  r_out_clip;

    logic [lpg_pkg::LVL_W-1:0]             w_lvl_clamp;
    logic signed [lpg_pkg::STATE_BITS-1:0] w_x;
    logic [lpg_pkg::LVL_W-1:0]             w_coef;
    logic signed [lpg_pkg::MA_W-1:0]       w_mul_a;
    logic signed [lpg_pkg::MB_W-1:0]       w_mul_b;
    logic signed [lpg_pkg::ACC_W-1:0]      w_round;
    logic [lpg_pkg::QUOT_W-1:0]            w_quot;
    logic                                  w_div_last;
    logic                                  w_out_fits;
    logic                                  w_mode_write;

    // Level clamp to one and sample widened to the state format.
    assign w_lvl_clamp = (i_level > lpg_pkg::ONE_Q15) ? lpg_pkg::ONE_Q15 : i_level;
    assign w_x = {{(lpg_pkg::STATE_BITS - lpg_pkg::SAMPLE_BITS){i_sample_in[
                    lpg_pkg::SAMPLE_BITS-1]}}, i_sample_in};

    // Configuration writes; a mode write copies low-pass to high-pass state if no finish.
    assign w_mode_write = i_cfg_we && ((i_cfg_idx == lpg_pkg::REG_FILTER_MODE) ||
                                       (i_cfg_idx == lpg_pkg::REG_HPF_ENABLE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode <= 1'b0;
            r_hpf_enable  <= 1'b0;
            r_offset      <= '0;
            r_hp_fb       <= lpg_pkg::HP_FB_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lpg_pkg::REG_FILTER_MODE:    r_filter_mode <= i_cfg_wdata[0];
                lpg_pkg::REG_HPF_ENABLE:     r_hpf_enable  <= i_cfg_wdata[0];
                lpg_pkg::REG_LOG_VOL_OFFSET: r_offset      <= i_cfg_wdata;
                lpg_pkg::REG_HP_FEEDBACK:
                    r_hp_fb <= i_cfg_wdata[lpg_pkg::HP_FB_W-1:0];
                default: ;
            endcase
        end
    end

    // Low-pass coefficient: level in filter mode, 0.5 + level/2 in gate mode.
    assign w_coef = r_filter_mode ? r_lvl : (lpg_pkg::HALF_Q15 + (r_lvl >> 1));

    // Multiplier operand selection.
    always_comb begin
        unique case (i_ctrl.mul)
            lpg_pkg::MUL_GAIN: begin
                w_mul_a = lpg_pkg::MA_W'(r_lp);
                w_mul_b = r_gain;
            end
            lpg_pkg::MUL_HPF: begin
                w_mul_a = lpg_pkg::MA_W'(r_hp_mem);
                w_mul_b = signed'({{(lpg_pkg::MB_W - lpg_pkg::HP_FB_W){1'b0}},
                                   r_hp_fb});
            end
            default: begin
                w_mul_a = r_diff;
                w_mul_b = signed'({{(lpg_pkg::MB_W - lpg_pkg::LVL_W){1'b0}}, w_coef});
            end
        endcase
    end

    // Product rounded half up with its 15 fraction bits shifted out.
    assign w_round = (lpg_pkg::ACC_W'(r_prod) + lpg_pkg::ROUND_HALF) >>> lpg_pkg::FRAC;

    // Serial divider for the filter-mode gain.
    lpg_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctrl.alu == lpg_pkg::ALU_DIV_START),
        .i_step  (i_ctrl.alu == lpg_pkg::ALU_DIV_STEP),
        .i_lvl   (r_lvl),
        .o_quot  (w_quot),
        .o_last  (w_div_last)
    );

    // Sample capture, multiplier register and ALU results.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_lvl  <= w_lvl_clamp;
            r_diff <= lpg_pkg::MA_W'(w_x) - lpg_pkg::MA_W'(r_lp_mem);
        end
        if (i_ctrl.mul != lpg_pkg::MUL_NONE) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        unique case (i_ctrl.alu)
            lpg_pkg::ALU_LP:
                r_lp <= lpg_pkg::sat_state(lpg_pkg::ACC_W'(r_lp_mem) + w_round);
            lpg_pkg::ALU_GAIN_DIV:
                r_gain <= signed'({{(lpg_pkg::GAIN_W - lpg_pkg::QUOT_W){1'b0}}, w_quot})
                          + lpg_pkg::GAIN_W'(r_offset);
            lpg_pkg::ALU_GAIN_GATE:
                r_gain <= signed'({{(lpg_pkg::GAIN_W - lpg_pkg::LVL_W){1'b0}}, r_lvl});
            lpg_pkg::ALU_LO:
                r_lo <= lpg_pkg::sat_state(w_round);
            lpg_pkg::ALU_HI:
                r_hi <= lpg_pkg::sat_state(lpg_pkg::ACC_W'(r_lo)
                                           - lpg_pkg::ACC_W'(r_lp_mem) + w_round);
            lpg_pkg::ALU_BYPASS:
                r_hi <= r_lo;
            default: ;
        endcase
    end

    // Filter state: updated when a sample finishes, else copied on a mode write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp_mem <= '0;
            r_hp_mem <= '0;
        end else if (i_ctrl.finish) begin
            r_lp_mem <= r_lo;
            r_hp_mem <= r_hi;
        end else if (w_mode_write) begin
            r_hp_mem <= r_lp_mem;
        end
    end

    // Output saturation to the sample width.
    assign w_out_fits = (&r_hi[lpg_pkg::STATE_BITS-1:lpg_pkg::SAMPLE_BITS-1]) ||
                        (~|r_hi[lpg_pkg::STATE_BITS-1:lpg_pkg::SAMPLE_BITS-1]);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.finish) begin
            r_out_clip <= !w_out_fits;
            if (w_out_fits) begin
                r_out_data <= r_hi[lpg_pkg::SAMPLE_BITS-1:0];
            end else if (r_hi[lpg_pkg::STATE_BITS-1]) begin
                r_out_data <= {1'b1, {(lpg_pkg::SAMPLE_BITS-1){1'b0}}};
            end else begin
                r_out_data <= {1'b0, {(lpg_pkg::SAMPLE_BITS-1){1'b1}}};
            end
        end
    end

    assign o_status.filter_mode = r_filter_mode;
    assign o_status.hpf_enable  = r_hpf_enable;
    assign o_status.div_last    = w_div_last;
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_data;
    assign o_clipped    = r_out_clip;

endmodule

FILE: src/lpg_sequencer.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on lpg_pkg.
module lpg_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  lpg_pkg::t_status i_status,
    output lpg_pkg::t_ctrl   o_ctrl,
    output logic             o_idle
);

    lpg_pkg::t_seq_state          r_state, n_state;
    logic [lpg_pkg::PC_W-1:0]     r_pc, n_pc;
    lpg_pkg::t_cword              w_cw;
    logic [lpg_pkg::PC_W-1:0]     w_pc_inc;

    assign w_cw     = lpg_pkg::ucode(r_pc);
    assign w_pc_inc = r_pc + 1'b1;

    // Next state and next step.
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        unique case (r_state)
            lpg_pkg::SEQ_IDLE: begin
                if (i_accept) begin
                    n_state = lpg_pkg::SEQ_RUN;
                    n_pc    = '0;
                end
            end
            lpg_pkg::SEQ_RUN: begin
                unique case (w_cw.jmp)
                    lpg_pkg::J_NEXT:     n_pc = w_pc_inc;
                    lpg_pkg::J_ALWAYS:   n_pc = w_cw.target;
                    lpg_pkg::J_IF_GATE:
                        n_pc = i_status.filter_mode ? w_pc_inc : w_cw.target;
                    lpg_pkg::J_IF_NOHPF:
                        n_pc = i_status.hpf_enable ? w_pc_inc : w_cw.target;
                    lpg_pkg::J_LOOP:
                        n_pc = i_status.div_last ? w_pc_inc : w_cw.target;
                    lpg_pkg::J_DONE: begin
                        // Hold on the last step until the output register is free.
                        if (i_status.out_free) begin
                            n_state = lpg_pkg::SEQ_IDLE;
                        end
                    end
                    default: n_pc = w_pc_inc;
                endcase
            end
            default: n_state = lpg_pkg::SEQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpg_pkg::SEQ_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    // Control word to the datapath.
    always_comb begin
        o_ctrl.mul    = lpg_pkg::MUL_NONE;
        o_ctrl.alu    = lpg_pkg::ALU_NONE;
        o_ctrl.finish = 1'b0;
        o_idle        = 1'b0;
        unique case (r_state)
            lpg_pkg::SEQ_IDLE: o_idle = 1'b1;
            lpg_pkg::SEQ_RUN: begin
                o_ctrl.mul    = w_cw.mul;
                o_ctrl.alu    = w_cw.alu;
                o_ctrl.finish = (w_cw.jmp == lpg_pkg::J_DONE) && i_status.out_free;
            end
            default: o_idle = 1'b0;
        endcase
    end

endmodule

FILE: src/low_pass_gate_with_hpf.sv
// Filter mode adds the 15-step serial divide to the gate-mode program, and the
// high-pass stage adds a multiply step; the microcode program and the shared
// multiplier handle one sample at a time.
// Reset (synchronous, active low) clears the filter state, loads the register defaults
// and empties the output register.
module low_pass_gate_with_hpf (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [lpg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lpg_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // Input stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,   // [15:0] level, [31:16] sample_in
    // Output stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [lpg_pkg::SAMPLE_BITS-1:0]   m_axis_tdata,   // [15:0] sample_out
    output logic [0:0]                        m_axis_tuser    // [0] clipped
);

    lpg_pkg::t_ctrl                         w_ctrl;
    lpg_pkg::t_status                       w_status;
    logic                                   w_idle;
    logic                                   w_accept;
    logic                                   w_clipped;
    logic signed [lpg_pkg::SAMPLE_BITS-1:0] w_sample_out;

    // Input transaction accepted only while the sequencer is idle.
    assign s_axis_tready = w_idle;
    assign w_accept      = s_axis_tvalid && w_idle;

    lpg_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_status (w_status),
        .o_ctrl   (w_ctrl),
        .o_idle   (w_idle)
    );

    lpg_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (w_accept),
        .i_level      (s_axis_tdata[15:0]),
        .i_sample_in  (s_axis_tdata[31:16]),
        .i_ctrl       (w_ctrl),
        .o_status     (w_status),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_sample_out (w_sample_out),
        .o_clipped    (w_clipped)
    );

    assign m_axis_tdata    = w_sample_out;
    assign m_axis_tuser[0] = w_clipped;

endmodule

FILE: src/lpg_checker.sv
// Port-level assertions for the low-pass gate, bound to the top level.
// Depends on nothing but the top-level ports.
module lpg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // A stalled output transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("output transaction changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // One sample at a time: an input transaction closes the input until it is done.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after an input transaction");

    // A new result appears exactly when the sequencer returns to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result shown while still busy");

    // A clipped sample sits at one of the two full-scale values.
    a_clip_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            ((m_axis_tdata == 16'h7fff) || (m_axis_tdata == 16'h8000)))
        else $error("clip flag set on an unsaturated sample");

endmodule

bind low_pass_gate_with_hpf lpg_checker u_lpg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/testbench.sv
// Self-checking testbench for the low-pass gate with its optional high-pass stage.
// Needs lpg_pkg (src/lpg_pkg.sv) and the low_pass_gate_with_hpf top level.
// Samples stream in and out with random gaps and receiver stalls; a class predicts each output.
`timescale 1ns / 100ps

module testbench;

    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 30;
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_ITEMS   = 100;

    // Predicts the gate output from the sample and level, and queues the outcomes.
    class lpg_scoreboard;

        typedef struct {
            logic [lpg_pkg::SAMPLE_BITS-1:0] sample_out;
            logic                            clipped;
        } t_gate_result;

        t_gate_result expected_outputs[$];
        int unsigned  errors;
        logic         filter_mode;
        logic         hpf_enable;
        longint       log_offset;
        longint       hp_fb;
        longint       lp_mem;
        longint       hp_mem;

        function new();
            errors      = 0;
            filter_mode = 1'b0;
            hpf_enable  = 1'b0;
            log_offset  = 0;
            hp_fb       = longint'(lpg_pkg::HP_FB_RESET);
            lp_mem      = 0;
            hp_mem      = 0;
        endfunction

        // Saturate to a signed range of the given width.
        function longint clamp(longint v, int bits);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        // Drop the 15 fraction bits, rounding half up.
        function longint q15_round(longint v);
            return (v + (longint'(1) <<< (lpg_pkg::FRAC - 1))) >>> lpg_pkg::FRAC;
        endfunction

        // A mode write copies the low-pass memory into the high-pass memory.
        function void write_reg(lpg_pkg::t_cfg_reg idx,
                                logic [lpg_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lpg_pkg::REG_FILTER_MODE: begin
                    filter_mode = data[0];
                    hp_mem = lp_mem;
                end
                lpg_pkg::REG_HPF_ENABLE: begin
                    hpf_enable = data[0];
                    hp_mem = lp_mem;
                end
                lpg_pkg::REG_LOG_VOL_OFFSET:
                    log_offset = longint'($signed(data[lpg_pkg::OFFSET_W-1:0]));
                lpg_pkg::REG_HP_FEEDBACK:
                    hp_fb = longint'(data[lpg_pkg::HP_FB_W-1:0]);
                default: ;
            endcase
        endfunction

        // Run one sample through the filter chain and store the expected output.
        function void note_sample(logic [lpg_pkg::LVL_W-1:0] level,
                                  logic signed [lpg_pkg::SAMPLE_BITS-1:0] sample);
            longint lvl, x, prev, lp, gain, den, coef, lo, hi, y;
            t_gate_result r;
            lvl = longint'(level);
            if (lvl > longint'(lpg_pkg::ONE_Q15)) lvl = longint'(lpg_pkg::ONE_Q15);
            x = clamp(longint'(sample), lpg_pkg::STATE_BITS);
            prev = lp_mem;
            if (filter_mode) begin
                den  = longint'(lpg_pkg::TENTH_Q15) + lvl;
                lp   = clamp(prev + q15_round(lvl * (x - prev)), lpg_pkg::STATE_BITS);
                gain = ((lvl <<< lpg_pkg::FRAC) + den / 2) / den + log_offset;
            end else begin
                coef = longint'(lpg_pkg::HALF_Q15) + (lvl >>> 1);
                lp   = clamp(prev + q15_round(coef * (x - prev)), lpg_pkg::STATE_BITS);
                gain = lvl;
            end
            lo = clamp(q15_round(lp * gain), lpg_pkg::STATE_BITS);
            if (hpf_enable) begin
                hi = clamp(lo - prev + q15_round(hp_fb * hp_mem), lpg_pkg::STATE_BITS);
            end else begin
                hi = lo;
            end
            lp_mem = lo;
            hp_mem = hi;
            y = clamp(hi, lpg_pkg::SAMPLE_BITS);
            r.sample_out = y[lpg_pkg::SAMPLE_BITS-1:0];
            r.clipped    = (y != hi);
            expected_outputs.push_back(r);
        endfunction

        // Compare one output transaction with the oldest expectation.
        function void check_output(logic [lpg_pkg::SAMPLE_BITS-1:0] sample_out,
                                   logic clipped);
            t_gate_result r;
            if (expected_outputs.size() == 0) begin
                $error("output transaction with nothing expected: sample_out %0d",
                       $signed(sample_out));
                errors++;
                return;
            end
            r = expected_outputs.pop_front();
            if (sample_out !== r.sample_out) begin
                $error("sample_out: expected %0d, got %0d",
                       $signed(r.sample_out), $signed(sample_out));
                errors++;
            end
            if (clipped !== r.clipped) begin
                $error("clipped: expected %0b, got %0b", r.clipped, clipped);
                errors++;
            end
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction

    endclass

    typedef enum {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC,
        RX_HOLD
    } t_rx_mode;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [lpg_pkg::CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [lpg_pkg::CFG_DATA_W-1:0]  i_cfg_wdata = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [31:0]                     s_axis_tdata = '0;   // [15:0] level, [31:16] sample_in
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [lpg_pkg::SAMPLE_BITS-1:0] m_axis_tdata;        // [15:0] sample_out
    logic [0:0]                      m_axis_tuser;        // [0] clipped

    lpg_scoreboard sb = new();

    int       burst_left = 1;
    bit       gaps_on = 1'b1;
    int       holds_requested = 0;
    int       holds_done = 0;
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_cycle = 0;

    low_pass_gate_with_hpf dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Give up long after the slowest correct run would have finished.
    initial begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: checks each output transaction and stalls in segments of its own.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_output(m_axis_tdata, m_axis_tuser[0]);
        end
        if (rx_left == 0) begin
            if (holds_done < holds_requested) begin
                rx_mode = RX_HOLD;
                rx_left = HOLD_CYCLES;
                holds_done++;
            end else begin
                case ($urandom_range(0, 15))
                    0:             rx_mode = RX_HOLD;
                    1, 2, 3, 4:    rx_mode = RX_OPEN;
                    5, 6, 7, 8:    rx_mode = RX_COIN;
                    9, 10, 11:     rx_mode = RX_SPARSE;
                    default:       rx_mode = RX_PERIODIC;
                endcase
                rx_left = (rx_mode == RX_HOLD) ? $urandom_range(60, 200)
                                               : $urandom_range(20, 150);
            end
        end
        rx_left--;
        rx_cycle++;
        case (rx_mode)
            RX_OPEN:     m_axis_tready <= 1'b1;
            RX_COIN:     m_axis_tready <= $urandom_range(0, 1);
            RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: m_axis_tready <= (rx_cycle % 7) > 2;
            default:     m_axis_tready <= 1'b0;
        endcase
    end

    // Offer one sample until the block takes it, then maybe pause between bursts.
    task automatic send_sample(input logic [lpg_pkg::LVL_W-1:0] level,
                               input logic [lpg_pkg::SAMPLE_BITS-1:0] sample);
        int gap;
        s_axis_tdata  <= {sample, level};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_sample(level, sample);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            if (gaps_on && $urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 30);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Register writes drive the enable with the index and data, then drop the enable before returning.
    task automatic write_reg(input lpg_pkg::t_cfg_reg idx,
                             input logic [lpg_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop offering, collect every pending output and let the sequencer settle.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [lpg_pkg::LVL_W-1:0]       level;
        logic [lpg_pkg::SAMPLE_BITS-1:0] sample;
        logic [lpg_pkg::SAMPLE_BITS-1:0] steady_value;
        logic [lpg_pkg::CFG_DATA_W-1:0]  data;
        bit                              steady;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Gate mode at reset settings, with levels at and above one.
        send_sample(16'd0, 16'h7FFF);
        send_sample(16'd32768, 16'h8000);
        send_sample(16'hFFFF, 16'h7FFF);
        send_sample(16'd40000, 16'hFFFF);
        send_sample(16'd16384, 16'h5555);
        send_sample(16'd1, 16'h8000);
        wait_idle();

        // Filter mode with the largest offset drives the state into saturation.
        write_reg(lpg_pkg::REG_FILTER_MODE, 16'd1);
        write_reg(lpg_pkg::REG_LOG_VOL_OFFSET, 16'h7FFF);
        send_sample(16'd0, 16'h7FFF);
        send_sample(16'd1, 16'h7FFF);
        send_sample(16'd32768, 16'h8000);
        send_sample(16'hFFFF, 16'd12345);
        send_sample(16'd3277, 16'h8000);
        wait_idle();

        // The most negative offset gives a negative gain.
        write_reg(lpg_pkg::REG_LOG_VOL_OFFSET, 16'h8000);
        send_sample(16'd32768, 16'h8000);
        send_sample(16'd100, 16'h7FFF);
        send_sample(16'd0, 16'hFFFF);
        wait_idle();

        // High-pass stage with the largest feedback coefficient.
        write_reg(lpg_pkg::REG_HPF_ENABLE, 16'd1);
        write_reg(lpg_pkg::REG_HP_FEEDBACK, 16'h7FFF);
        send_sample(16'd32768, 16'h7FFF);
        send_sample(16'd32768, 16'h8000);
        send_sample(16'd32768, 16'h7FFF);
        send_sample(16'd0, 16'd0);
        wait_idle();

        // Rewriting the same mode still copies the state; then back to gate mode.
        write_reg(lpg_pkg::REG_FILTER_MODE, 16'hFFFF);
        write_reg(lpg_pkg::REG_FILTER_MODE, 16'hFFFE);
        write_reg(lpg_pkg::REG_HP_FEEDBACK, 16'h8000);
        send_sample(16'd32768, 16'h7FFF);
        send_sample(16'd50000, 16'h8000);
        send_sample(16'd0, 16'd1);
        wait_idle();

        // Random phases, each under its own settings.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if ($urandom_range(0, 3) != 0) begin
                data = 16'($urandom);
                write_reg(lpg_pkg::REG_FILTER_MODE, data);
            end
            if ($urandom_range(0, 3) != 0) begin
                data = 16'($urandom);
                write_reg(lpg_pkg::REG_HPF_ENABLE, data);
            end
            case ($urandom_range(0, 4))
                0:       data = 16'h7FFF;
                1:       data = 16'h8000;
                2:       data = 16'd0;
                default: data = 16'($urandom);
            endcase
            write_reg(lpg_pkg::REG_LOG_VOL_OFFSET, data);
            case ($urandom_range(0, 4))
                0:       data = {1'($urandom), 15'h7FFF};
                1:       data = {1'($urandom), 15'd0};
                2:       data = {1'($urandom), 15'(lpg_pkg::HP_FB_RESET)};
                default: data = 16'($urandom);
            endcase
            write_reg(lpg_pkg::REG_HP_FEEDBACK, data);

            gaps_on = ($urandom_range(0, 3) != 0);
            steady = ($urandom_range(0, 3) == 0);
            steady_value = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            // Long receiver hold-offs while samples keep coming fill the block up.
            if (phase == 0 || phase == RANDOM_PHASES / 2) holds_requested++;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(0, 9))
                    0:       level = 16'd0;
                    1:       level = lpg_pkg::ONE_Q15;
                    2:       level = 16'($urandom_range(32769, 65535));
                    3:       level = 16'($urandom_range(0, 600));
                    default: level = 16'($urandom_range(0, 32768));
                endcase
                if (steady && $urandom_range(0, 3) != 0) begin
                    sample = steady_value;
                end else begin
                    case ($urandom_range(0, 7))
                        0:       sample = 16'h8000;
                        1:       sample = 16'h7FFF;
                        default: sample = 16'($urandom);
                    endcase
                end
                send_sample(level, sample);
            end
            wait_idle();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
